// ----- rtl/cdq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the circular deque unit.
// No dependencies.
package cdq_pkg;

  localparam int DEPTH      = 8;
  localparam int WORD_W     = 32;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } cdq_op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cdq_status_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic    en;
    cdq_op_t op;
  } cdq_ctrl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic              occ;
    logic [WORD_W-1:0] data;
  } cdq_link_t;

endpackage

// ----- rtl/cdq_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the shifting deque row.
// Depends on cdq_pkg.
module cdq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  cdq_pkg::cdq_ctrl_t        ctrl,
  input  logic [cdq_pkg::WORD_W-1:0] item,
  input  cdq_pkg::cdq_link_t        lo,       // neighbor nearer the front
  input  cdq_pkg::cdq_link_t        hi,       // neighbor nearer the back
  input  logic [cdq_pkg::WORD_W-1:0] rear_in,  // rear-word tap from the back side
  output cdq_pkg::cdq_link_t        own,
  output logic [cdq_pkg::WORD_W-1:0] rear_out
);
  import cdq_pkg::*;

  logic              occ;
  logic              occ_next;
  logic [WORD_W-1:0] data;
  logic [WORD_W-1:0] data_next;
  logic              is_rear;

  // This cell holds the rear word when it is the last occupied one.
  assign is_rear  = occ && !hi.occ;
  assign rear_out = rear_in | (is_rear ? data : '0);
  assign own      = '{occ: occ, data: data};

  always_comb begin
    occ_next  = occ;
    data_next = data;
    if (ctrl.en) begin
      unique case (ctrl.op)
        OP_PUSH_FRONT: begin
          occ_next  = lo.occ;
          data_next = lo.data;
        end
        OP_PUSH_REAR: begin
          if (!occ && lo.occ) begin
            occ_next  = 1'b1;
            data_next = item;
          end
        end
        OP_POP_FRONT: begin
          occ_next  = hi.occ;
          data_next = hi.data;
        end
        OP_POP_REAR: begin
          if (is_rear) occ_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
    data <= data_next;
  end

endmodule

// ----- rtl/circular_deque_unit.sv -----
`timescale 1ns / 1ps
// Top level of the circular deque: a row of shifting cells plus a result register.
// Depends on cdq_pkg and cdq_cell.
//
//  channel | dir | tdata                                  | tuser
//  s_axis  | in  | item[31:0]                             | func[1:0]
//  m_axis  | out | popped[31:0], now_empty, now_full, 0s  | status[1:0]
//
// Rate: one word per clock while the output register is not stalled. An accepted
// word updates the cell row, and its result lands in the output register at the
// same edge.
// Reset: rst clears every occupancy bit (deque empty) and the output valid.
// Stalls: s_axis_tready stays high while the output register is empty or
// being drained, so input and output run back to back.
//
// The front word always sits in cell 0; occupied cells form a contiguous run
// from cell 0 upward. Push front shifts the row up, pop front shifts it down,
// push/pop rear touches only the boundary cell. The rear word reaches the top
// through an OR chain running from the back of the row toward cell 0.
module circular_deque_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] item
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] popped, [32] now_empty, [33] now_full, rest 0
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import cdq_pkg::*;

  cdq_link_t         own   [DEPTH];
  logic [WORD_W-1:0] rear  [DEPTH];
  cdq_ctrl_t         ctrl;
  cdq_op_t           op;
  logic              accept;
  logic              is_empty;
  logic              is_full;
  logic              is_push;
  logic              refused;

  // result register
  logic              out_valid;
  cdq_status_t       out_status;
  logic [WORD_W-1:0] out_popped;
  logic              out_empty;
  logic              out_full;

  cdq_status_t       status_next;
  logic [WORD_W-1:0] popped_next;
  logic              empty_next;
  logic              full_next;

  assign op       = cdq_op_t'(s_axis_tuser);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_empty = !own[0].occ;
  assign is_full  = own[DEPTH-1].occ;
  assign is_push  = (op == OP_PUSH_FRONT) || (op == OP_PUSH_REAR);
  assign refused  = is_push ? is_full : is_empty;

  // Cells only move on an accepted, non-refused operation.
  assign ctrl = '{en: accept && !refused, op: op};

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_row
      cdq_link_t         lo_l;
      cdq_link_t         hi_l;
      logic [WORD_W-1:0] rear_in_l;
      if (g == 0) begin : g_first
        assign lo_l = '{occ: 1'b1, data: s_axis_tdata};
      end else begin : g_mid_lo
        assign lo_l = own[g-1];
      end
      if (g == DEPTH-1) begin : g_last
        assign hi_l      = '{occ: 1'b0, data: '0};
        assign rear_in_l = '0;
      end else begin : g_mid_hi
        assign hi_l      = own[g+1];
        assign rear_in_l = rear[g+1];
      end
      cdq_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .item     (s_axis_tdata),
        .lo       (lo_l),
        .hi       (hi_l),
        .rear_in  (rear_in_l),
        .own      (own[g]),
        .rear_out (rear[g])
      );
    end
  endgenerate

  // Result of the current operation, from the occupancy before the update.
  always_comb begin
    status_next = ST_DONE;
    popped_next = '0;
    empty_next  = is_empty;
    full_next   = is_full;
    if (is_push) begin
      empty_next = 1'b0;
      if (is_full) begin
        status_next = ST_FULL;
      end else begin
        full_next = own[DEPTH-2].occ;
      end
    end else begin
      if (is_empty) begin
        status_next = ST_EMPTY;
      end else begin
        popped_next = (op == OP_POP_FRONT) ? own[0].data : rear[0];
        empty_next  = !own[1].occ;
        full_next   = 1'b0;
      end
    end
  end

  assign s_axis_tready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (accept) begin
      out_status <= status_next;
      out_popped <= popped_next;
      out_empty  <= empty_next;
      out_full   <= full_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {{(OUT_DATA_W-WORD_W-2){1'b0}}, out_full, out_empty, out_popped};

endmodule

// ----- rtl/cdq_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for circular_deque_unit, bound to the top level.
// Depends on cdq_pkg.
module cdq_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import cdq_pkg::*;

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Empty and full never both report.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[32] && m_axis_tdata[33]))
    else $error("now_empty and now_full both set");

  // Refused operations carry no popped word.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_EMPTY)
      |-> m_axis_tdata[31:0] == '0)
    else $error("refused operation returned data");

  // A full refusal agrees with the reported full flag.
  a_refused_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> m_axis_tdata[33])
    else $error("full refusal without full flag");

  // Status is one of the defined codes and the tdata padding stays zero.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_DONE || m_axis_tuser == ST_FULL
      || m_axis_tuser == ST_EMPTY) && m_axis_tdata[39:34] == '0)
    else $error("bad status code or padding");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/circular_deque_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for circular_deque_unit: directed and random deque words checked
// against a pointer-based shadow deque. Depends on cdq_pkg and the deque RTL.
module circular_deque_unit_tb;
  import cdq_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 320;
  localparam int SETTLE_CYCLES   = 10;

  typedef struct packed {
    cdq_op_t     op;
    logic [31:0] word;
    logic        wait_drain;  // hold this word back until all results are in
  } deque_req_t;

  typedef struct packed {
    cdq_status_t status;
    logic [31:0] popped;
    logic        now_empty;
    logic        now_full;
  } deque_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = OP_PUSH_FRONT;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  circular_deque_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Shadow deque: circular store with front/rear indexes and a vacancy flag.
  logic [31:0] shadow_word [DEPTH];
  int unsigned front_idx = 0;
  int unsigned rear_idx  = 0;
  bit          shadow_vacant = 1'b1;

  deque_req_t    pending_words [$];
  deque_result_t awaited_results [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;
  bit hold_taken     = 1'b0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int mismatches     = 0;
  int results_seen   = 0;
  int pops_done      = 0;
  int full_refusals  = 0;
  int empty_refusals = 0;
  int full_reached   = 0;

  deque_result_t predicted;
  deque_result_t oldest;

  function automatic int unsigned step_up(int unsigned i);
    return (i + 1 >= DEPTH) ? 0 : i + 1;
  endfunction

  function automatic int unsigned step_down(int unsigned i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  function automatic bit shadow_full();
    return !shadow_vacant && front_idx == step_up(rear_idx);
  endfunction

  // Applies one operation to the shadow deque and returns the result word it should give.
  function automatic deque_result_t deque_apply(cdq_op_t op, logic [31:0] word);
    deque_result_t r;
    r.status = ST_DONE;
    r.popped = '0;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
      if (shadow_full()) begin
        r.status = ST_FULL;
      end else if (shadow_vacant) begin
        // first word always lands in entry 0
        front_idx = 0;
        rear_idx = 0;
        shadow_vacant = 1'b0;
        shadow_word[0] = word;
      end else if (op == OP_PUSH_FRONT) begin
        front_idx = step_down(front_idx);
        shadow_word[front_idx] = word;
      end else begin
        rear_idx = step_up(rear_idx);
        shadow_word[rear_idx] = word;
      end
    end else begin
      if (shadow_vacant) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped = (op == OP_POP_FRONT) ? shadow_word[front_idx] : shadow_word[rear_idx];
        if (front_idx == rear_idx) begin
          // last word gone: pointers go home
          front_idx = 0;
          rear_idx = 0;
          shadow_vacant = 1'b1;
        end else if (op == OP_POP_FRONT) begin
          front_idx = step_up(front_idx);
        end else begin
          rear_idx = step_down(rear_idx);
        end
      end
    end
    r.now_empty = shadow_vacant;
    r.now_full  = shadow_full();
    return r;
  endfunction

  // Driver: predicts each accepted word, then offers the next pending one.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = deque_apply(cdq_op_t'(s_axis_tuser), s_axis_tdata);
        awaited_results.push_back(predicted);
        if (predicted.status == ST_FULL) full_refusals++;
        if (predicted.status == ST_EMPTY) empty_refusals++;
        if (predicted.now_full) full_reached++;
        if (predicted.status == ST_DONE &&
            (s_axis_tuser == OP_POP_FRONT || s_axis_tuser == OP_POP_REAR)) pops_done++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(pending_words[0].wait_drain && awaited_results.size() > 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_words[0].word;
          s_axis_tuser  <= pending_words[0].op;
          void'(pending_words.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: each result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result word with nothing awaited: status %0d data %h",
               m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        oldest = awaited_results.pop_front();
        results_seen++;
        if (m_axis_tuser !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[31:0] !== oldest.popped) begin
          $error("popped: expected %h, got %h", oldest.popped, m_axis_tdata[31:0]);
          mismatches++;
        end
        if (m_axis_tdata[32] !== oldest.now_empty) begin
          $error("now_empty: expected %0b, got %0b", oldest.now_empty, m_axis_tdata[32]);
          mismatches++;
        end
        if (m_axis_tdata[33] !== oldest.now_full) begin
          $error("now_full: expected %0b, got %0b", oldest.now_full, m_axis_tdata[33]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results awaited",
               cycle_count, awaited_results.size());
      $display("circular_deque_unit_tb NOT OK");
      $finish;
    end
  end

  task automatic queue_word(cdq_op_t op, logic [31:0] word, logic wait_drain);
    deque_req_t q;
    q.op = op;
    q.word = word;
    q.wait_drain = wait_drain;
    pending_words.push_back(q);
  endtask

  task automatic wait_all_done();
    while (pending_words.size() > 0 || awaited_results.size() > 0 || s_axis_tvalid)
      @(posedge clk);
  endtask

  // Random words in alternating fill and drain stretches so full and empty both get hit.
  task automatic queue_random(int count);
    bit      fill_bias;
    bit      is_pop;
    bit      at_rear;
    int      pick;
    logic [31:0] w;
    fill_bias = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) fill_bias = ~fill_bias;
      if ($urandom_range(0, 9) == 0)
        is_pop = 1'($urandom_range(0, 1));
      else
        is_pop = ($urandom_range(0, 99) < (fill_bias ? 25 : 75));
      at_rear = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 15);
      case (pick)
        0: w = 32'h8000_0000;
        1: w = 32'h7fff_ffff;
        2: w = 32'hffff_ffff;
        3: w = 32'h0000_0000;
        default: w = $urandom;
      endcase
      queue_word(is_pop ? (at_rear ? OP_POP_REAR : OP_POP_FRONT)
                        : (at_rear ? OP_PUSH_REAR : OP_PUSH_FRONT),
                 w, (i % 60 == 59));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: refusals on empty, single-word push/pop, fill past full, drain past empty.
    queue_word(OP_POP_FRONT, 32'h1234_5678, 1'b0);
    queue_word(OP_POP_REAR, 32'h8765_4321, 1'b0);
    queue_word(OP_PUSH_FRONT, 32'h8000_0000, 1'b0);
    queue_word(OP_POP_REAR, '0, 1'b0);
    queue_word(OP_PUSH_REAR, 32'h7fff_ffff, 1'b0);
    queue_word(OP_POP_FRONT, '0, 1'b0);
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: queue_word(OP_PUSH_FRONT, 32'hffff_ffff - i, 1'b0);
        1: queue_word(OP_PUSH_REAR, 32'haaaa_aaaa, 1'b0);
        2: queue_word(OP_PUSH_FRONT, 32'h5555_5555 + i, 1'b0);
        default: queue_word(OP_PUSH_REAR, 32'h8000_0000 + i, 1'b0);
      endcase
    end
    queue_word(OP_PUSH_FRONT, 32'h0bad_0001, 1'b0);
    queue_word(OP_PUSH_REAR, 32'h0bad_0002, 1'b0);
    for (int i = 0; i < DEPTH; i++)
      queue_word((i % 2) ? OP_POP_REAR : OP_POP_FRONT, $urandom, 1'b0);
    queue_word(OP_POP_FRONT, '0, 1'b0);
    wait_all_done();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_request = 1'b1; end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      queue_random(ITEMS_PER_PHASE);
      wait_all_done();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d result words, %0d successful pops, deque full %0d times",
             results_seen, pops_done, full_reached);
    $display("refused pushes when full: %0d, refused pops when empty: %0d",
             full_refusals, empty_refusals);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("circular_deque_unit_tb OK");
    end else begin
      $display("circular_deque_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cdq_pkg.sv
rtl/cdq_cell.sv
rtl/circular_deque_unit.sv
rtl/cdq_checker.sv
tb/circular_deque_unit_tb.sv
